@@ design/spiadc_pkg.sv @@
// Shared types, constants and controller/datapath interface of the SPI converter reader.
package spiadc_pkg;

   localparam int ChannelW           = 4;
   localparam int ReadCountW         = 8;
   localparam int HalfPeriodW        = 16;
   localparam int AvgW               = 11;
   localparam int ChanSelW           = 3;
   localparam int CommandBits        = 5;
   localparam int CmdShiftW          = 8;
   localparam int ReceiveBitsDefault = 12;
   localparam int MaxReads           = 255;

   localparam logic [ChannelW-1:0]    MaxChannel      = 4'd7;
   localparam logic [HalfPeriodW-1:0] HalfPeriodReset = 16'd200;
   // start bit and single-ended bit ahead of the channel select
   localparam logic [1:0]             CmdPrefix       = 2'b11;
   localparam logic [AvgW-1:0]        AvgMax          = '1;

   typedef struct packed {
      logic                  start_req;
      logic [ChannelW-1:0]   channel;
      logic [ReadCountW-1:0] read_count;
      logic                  miso;
   } req_type;

   typedef struct packed {
      logic            sclk;
      logic            mosi;
      logic            cs_n;
      logic            busy_res;
      logic            done_res;
      logic            error;
      logic [AvgW-1:0] average;
   } rsp_type;

   typedef enum logic [9:0] {
      ST_IDLE     = 10'b0000000001,
      ST_SETUP    = 10'b0000000010,
      ST_CMD_LOW  = 10'b0000000100,
      ST_CMD_HIGH = 10'b0000001000,
      ST_RX_LOW   = 10'b0000010000,
      ST_RX_HIGH  = 10'b0000100000,
      ST_TAIL     = 10'b0001000000,
      ST_DIV_LOAD = 10'b0010000000,
      ST_DIV_RUN  = 10'b0100000000,
      ST_FINISH   = 10'b1000000000
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;         // latch channel and count, clear sum
      logic begin_frame;  // reload command shifter, clear counters
      logic run;          // advance the phase tick counter
      logic shift_cmd;    // next command bit
      logic bit_inc;
      logic bit_clear;
      logic sample;       // shift miso into the receive register
      logic accumulate;   // add frame value, count down reads
      logic div_start;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic            phase_over;
      logic            tick_zero;
      logic            bit_nonzero;
      logic            cmd_last;
      logic            rx_last;
      logic            last_read;
      logic            mosi_bit;
      logic            div_done;
      logic [AvgW-1:0] quotient;
   } dp_sts_type;

endpackage

@@ design/spi_adc_channel_reader_averaging.sv @@
// Top level: SPI converter reader with averaging, one item per time tick.
//
//  port group  dir  handshake            payload
//  req_*       in   req_valid/req_ready  req_type: start_req, channel, read_count, miso
//  rsp_*       out  rsp_valid/rsp_ready  rsp_type: pins, busy, done, error, average
//  csr_*       in   csr_we (no wait)     csr_wdata: half period in ticks
//
// Every accepted item is one tick and yields exactly one item on rsp.
// Ticks are taken one per clock while a request runs or the block is idle, as long as the rsp side does not stall.
// After the tail of the last frame the input stalls in the divider load and run states
// while the restoring divider forms the average.
// rsp sits behind one output register; a new item is taken as soon as the
// waiting one leaves, so a stalled rsp side stalls req by the same amount.
// Synchronous active-high reset; half period comes up at 200 ticks.
module spi_adc_channel_reader_averaging import spiadc_pkg::*; #(
   parameter int RECEIVE_BITS = ReceiveBitsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [HalfPeriodW-1:0] csr_wdata
);

   dp_cmd_type cmd;
   dp_sts_type sts;
   rsp_type    rsp_next;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       tick;
   logic       out_free;

   // output slot is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign tick     = req_valid && req_ready;

   spiadc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .tick      (tick),
      .out_free  (out_free),
      .sts       (sts),
      .req_ready (req_ready),
      .cmd       (cmd),
      .rsp_next  (rsp_next)
   );

   spiadc_dpath #(
      .RECEIVE_BITS (RECEIVE_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts)
   );

   // output register: loaded with the pin levels of each accepted tick
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (tick) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rsp_next;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ design/spiadc_div.sv @@
// Restoring divider, one quotient bit per cycle.
module spiadc_div import spiadc_pkg::*; #(
   parameter int DIVIDEND_W = ReceiveBitsDefault - 1 + ReadCountW,
   parameter int DIVISOR_W  = ReadCountW
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CntW = $clog2(DIVIDEND_W + 1);

   logic [CntW-1:0]       cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W-1:0]  diff;
   logic                  fits, running;

   assign running = (cnt_ff != '0);
   assign trial   = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign fits    = (trial >= {1'b0, dvs_ff});
   // remainder after a fitting subtract is below the divisor, so the low bits suffice
   assign diff    = trial[DIVISOR_W-1:0] - dvs_ff;

   always_comb begin
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = CntW'(DIVIDEND_W);
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (running) begin
         cnt_in  = cnt_ff - 1'b1;
         quo_in  = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in  = fits ? diff : trial[DIVISOR_W-1:0];
         done_in = (cnt_ff == CntW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ design/spiadc_dpath.sv @@
// Datapath: phase timer, bit counter, shifters, accumulator and averaging divider.
module spiadc_dpath import spiadc_pkg::*; #(
   parameter int RECEIVE_BITS = ReceiveBitsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [HalfPeriodW-1:0] csr_wdata,
   input  req_type                req_data,
   input  dp_cmd_type             cmd,
   output dp_sts_type             sts
);

   localparam int RxValW = RECEIVE_BITS - 1;
   localparam int SumW   = RxValW + ReadCountW;
   localparam int BitW   = $clog2(RECEIVE_BITS);
   localparam logic [SumW-1:0] AvgMaxWide = SumW'(AvgMax);

   logic [HalfPeriodW-1:0]  half_ff, half_in;
   logic [HalfPeriodW-1:0]  tick_ff, tick_in;
   logic [BitW-1:0]         bit_ff, bit_in;
   logic [CmdShiftW-1:0]    cmdsh_ff, cmdsh_in;
   logic [RECEIVE_BITS-1:0] rx_ff, rx_in;
   logic [SumW-1:0]         sum_ff, sum_in;
   logic [ReadCountW-1:0]   remain_ff, remain_in;
   logic [ReadCountW-1:0]   reads_ff, reads_in;
   logic [ChanSelW-1:0]     chan_ff, chan_in;
   logic [AvgW-1:0]         quot_ff, quot_in;

   logic [HalfPeriodW-1:0]  phase_len;
   logic                    phase_over;
   logic [ChanSelW-1:0]     chan_src;
   logic [BitW:0]           bit_plus;
   logic                    div_done;
   logic [SumW-1:0]         div_q;

   // a zero half period behaves as one tick
   assign phase_len  = (half_ff == '0) ? HalfPeriodW'(1) : half_ff;
   assign phase_over = ({1'b0, tick_ff} + 1'b1) >= {1'b0, phase_len};
   assign bit_plus   = {1'b0, bit_ff} + 1'b1;
   assign chan_src   = cmd.load ? req_data.channel[ChanSelW-1:0] : chan_ff;

   always_comb begin
      half_in   = csr_we ? csr_wdata : half_ff;
      tick_in   = tick_ff;
      bit_in    = bit_ff;
      cmdsh_in  = cmdsh_ff;
      rx_in     = rx_ff;
      sum_in    = sum_ff;
      remain_in = remain_ff;
      reads_in  = reads_ff;
      chan_in   = chan_ff;
      quot_in   = quot_ff;

      if (cmd.load) begin
         chan_in   = req_data.channel[ChanSelW-1:0];
         reads_in  = req_data.read_count;
         remain_in = req_data.read_count;
         sum_in    = '0;
      end

      if (cmd.begin_frame) begin
         cmdsh_in = {CmdPrefix, chan_src, {(CmdShiftW - ChanSelW - 2){1'b0}}};
         rx_in    = '0;
         bit_in   = '0;
         tick_in  = '0;
      end

      if (cmd.run) begin
         tick_in = phase_over ? '0 : tick_ff + 1'b1;
      end
      if (cmd.shift_cmd) begin
         cmdsh_in = {cmdsh_ff[CmdShiftW-2:0], 1'b0};
      end
      if (cmd.bit_clear) begin
         bit_in = '0;
      end else if (cmd.bit_inc) begin
         bit_in = bit_plus[BitW-1:0];
      end

      if (cmd.sample) begin
         rx_in = {rx_ff[RECEIVE_BITS-2:0], req_data.miso};
      end
      // the last bit clocked in is dropped
      if (cmd.accumulate) begin
         sum_in = sum_ff + SumW'(rx_in[RECEIVE_BITS-1:1]);
         if (remain_ff != '0) begin
            remain_in = remain_ff - 1'b1;
         end
      end

      if (div_done) begin
         quot_in = (div_q > AvgMaxWide) ? AvgMax : div_q[AvgW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff   <= HalfPeriodReset;
         tick_ff   <= '0;
         bit_ff    <= '0;
         cmdsh_ff  <= '0;
         rx_ff     <= '0;
         sum_ff    <= '0;
         remain_ff <= '0;
         reads_ff  <= '0;
         chan_ff   <= '0;
         quot_ff   <= '0;
      end else begin
         half_ff   <= half_in;
         tick_ff   <= tick_in;
         bit_ff    <= bit_in;
         cmdsh_ff  <= cmdsh_in;
         rx_ff     <= rx_in;
         sum_ff    <= sum_in;
         remain_ff <= remain_in;
         reads_ff  <= reads_in;
         chan_ff   <= chan_in;
         quot_ff   <= quot_in;
      end
   end

   spiadc_div #(
      .DIVIDEND_W (SumW),
      .DIVISOR_W  (ReadCountW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_ff),
      .divisor  (reads_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign sts.phase_over  = phase_over;
   assign sts.tick_zero   = (tick_ff == '0);
   assign sts.bit_nonzero = (bit_ff != '0);
   assign sts.cmd_last    = bit_plus >= (BitW+1)'(CommandBits);
   assign sts.rx_last     = bit_plus >= (BitW+1)'(RECEIVE_BITS);
   assign sts.last_read   = (remain_ff <= ReadCountW'(1));
   assign sts.mosi_bit    = cmdsh_ff[CmdShiftW-1];
   assign sts.div_done    = div_done;
   assign sts.quotient    = quot_ff;

endmodule

@@ design/spiadc_ctrl.sv @@
// Controller: frame sequencing state machine, datapath commands and pin levels.
module spiadc_ctrl import spiadc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  logic       tick,
   input  logic       out_free,
   input  dp_sts_type sts,
   output logic       req_ready,
   output dp_cmd_type cmd,
   output rsp_type    rsp_next
);

   state_type state_ff, state_in;
   logic      req_ok;
   logic      accept_state;

   assign req_ok = (req_data.channel <= MaxChannel) &&
                   (req_data.read_count != '0) &&
                   (int'(req_data.read_count) <= MaxReads);

   always_comb begin
      cmd              = '0;
      rsp_next         = '0;
      rsp_next.cs_n    = 1'b1;
      state_in         = state_ff;
      accept_state     = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_data.start_req) begin
               if (req_ok) begin
                  rsp_next.busy_res = 1'b1;
                  cmd.load          = tick;
                  cmd.begin_frame   = tick;
                  if (tick) state_in = ST_CMD_LOW;
               end else begin
                  rsp_next.done_res = 1'b1;
                  rsp_next.error    = 1'b1;
               end
            end
         end
         ST_SETUP: begin
            rsp_next.busy_res = 1'b1;
            cmd.begin_frame   = tick;
            if (tick) state_in = ST_CMD_LOW;
         end
         ST_CMD_LOW: begin
            rsp_next.busy_res = 1'b1;
            rsp_next.cs_n     = 1'b0;
            rsp_next.mosi     = sts.mosi_bit;
            cmd.run           = tick;
            if (tick && sts.phase_over) state_in = ST_CMD_HIGH;
         end
         ST_CMD_HIGH: begin
            rsp_next.busy_res = 1'b1;
            rsp_next.cs_n     = 1'b0;
            rsp_next.sclk     = 1'b1;
            rsp_next.mosi     = sts.mosi_bit;
            cmd.run           = tick;
            if (tick && sts.phase_over) begin
               cmd.shift_cmd = 1'b1;
               if (sts.cmd_last) begin
                  cmd.bit_clear = 1'b1;
                  state_in      = ST_RX_LOW;
               end else begin
                  cmd.bit_inc = 1'b1;
                  state_in    = ST_CMD_LOW;
               end
            end
         end
         ST_RX_LOW: begin
            rsp_next.busy_res = 1'b1;
            rsp_next.cs_n     = 1'b0;
            cmd.run           = tick;
            cmd.sample        = tick && sts.tick_zero && sts.bit_nonzero;
            if (tick && sts.phase_over) state_in = ST_RX_HIGH;
         end
         ST_RX_HIGH: begin
            rsp_next.busy_res = 1'b1;
            rsp_next.cs_n     = 1'b0;
            rsp_next.sclk     = 1'b1;
            cmd.run           = tick;
            if (tick && sts.phase_over) begin
               if (sts.rx_last) begin
                  cmd.bit_clear = 1'b1;
                  state_in      = ST_TAIL;
               end else begin
                  cmd.bit_inc = 1'b1;
                  state_in    = ST_RX_LOW;
               end
            end
         end
         ST_TAIL: begin
            rsp_next.busy_res = 1'b1;
            rsp_next.cs_n     = 1'b0;
            cmd.run           = tick;
            cmd.sample        = tick && sts.tick_zero;
            if (tick && sts.phase_over) begin
               cmd.accumulate = 1'b1;
               state_in       = sts.last_read ? ST_DIV_LOAD : ST_SETUP;
            end
         end
         ST_DIV_LOAD: begin
            accept_state  = 1'b0;
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            accept_state = 1'b0;
            if (sts.div_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            rsp_next.done_res = 1'b1;
            rsp_next.average  = sts.quotient;
            if (tick) state_in = ST_IDLE;
         end
         default: begin
            accept_state = 1'b0;
            state_in     = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = accept_state && out_free;

endmodule

@@ design/spiadc_checker.sv @@
// Port-level checks for the SPI converter reader, bound to the top level.
module spiadc_checker import spiadc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp item dropped or changed while stalled");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> !rsp_data.busy_res)
      else $error("done reported while busy");

   a_error_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error |-> rsp_data.done_res && rsp_data.average == '0)
      else $error("error without done or with nonzero average");

   a_sclk_in_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.sclk |-> !rsp_data.cs_n && rsp_data.busy_res)
      else $error("sclk pulse outside a selected frame");

   a_mosi_in_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.mosi |-> !rsp_data.cs_n && rsp_data.busy_res)
      else $error("mosi driven outside a selected frame");

endmodule

bind spi_adc_channel_reader_averaging spiadc_checker u_spiadc_checker (.*);

@@ sim/spi_adc_channel_reader_averaging_test.sv @@
// Testbench for the averaging SPI converter reader: per-tick pin and result checking.
`timescale 1ns / 1ps

module spi_adc_channel_reader_averaging_test;
   import spiadc_pkg::*;

   localparam int RxBits       = ReceiveBitsDefault;
   localparam int SettleCycles = RxBits + 20;   // divider stall plus output register slack
   localparam int CycleLimit   = 200000;
   localparam int MaxReport    = 10;

   // miso drive styles for directed conversions
   localparam int MisoZeros  = 0;
   localparam int MisoOnes   = 1;
   localparam int MisoRandom = 2;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_SETUP,
      SEQ_CMD_LOW,
      SEQ_CMD_HIGH,
      SEQ_RX_LOW,
      SEQ_RX_HIGH,
      SEQ_TAIL,
      SEQ_FINISH
   } seq_phase_type;

   // Tracks the sequencer tick by tick and holds the pin levels each tick should produce.
   class pin_trace_checker;
      logic [HalfPeriodW-1:0] half_period;
      seq_phase_type          phase;
      logic [HalfPeriodW-1:0] tick_count;
      logic [3:0]             bit_count;
      logic [CmdShiftW-1:0]   cmd_bits;
      logic [RxBits-1:0]      rx_bits;
      int unsigned            sum;
      logic [ReadCountW-1:0]  reads_left;
      logic [ReadCountW-1:0]  reads_total;
      logic [ChanSelW-1:0]    chan;
      logic [AvgW-1:0]        quotient;
      rsp_type                expected_pins[$];
      int                     mismatches;
      int                     ticks;
      int                     conversions;
      int                     refusals;

      function new();
         half_period = HalfPeriodReset;
         phase       = SEQ_IDLE;
         tick_count  = '0;
         bit_count   = '0;
         cmd_bits    = '0;
         rx_bits     = '0;
         sum         = 0;
         reads_left  = '0;
         reads_total = '0;
         chan        = '0;
         quotient    = '0;
         mismatches  = 0;
         ticks       = 0;
         conversions = 0;
         refusals    = 0;
      endfunction

      function bit is_idle();
         return phase == SEQ_IDLE;
      endfunction

      function int pending();
         return expected_pins.size();
      endfunction

      // end of a clock phase; a zero half period counts as one tick
      function bit phase_done();
         int unsigned len;
         len = (half_period == 0) ? 1 : 32'(half_period);
         if (32'(tick_count) + 1 >= len) begin
            tick_count = '0;
            return 1'b1;
         end
         tick_count++;
         return 1'b0;
      endfunction

      function void start_frame();
         cmd_bits   = {CmdPrefix, chan, 3'b000};
         rx_bits    = '0;
         bit_count  = '0;
         tick_count = '0;
         phase      = SEQ_CMD_LOW;
      endfunction

      function void shift_in(logic bit_in);
         rx_bits = {rx_bits[RxBits-2:0], bit_in};
      endfunction

      function rsp_type predict_tick(req_type item);
         rsp_type     pins;
         int unsigned q;
         pins      = '0;
         pins.cs_n = 1'b1;
         case (phase)
            SEQ_IDLE: begin
               if (item.start_req) begin
                  if (item.channel > MaxChannel || item.read_count == 0) begin
                     pins.done_res = 1'b1;
                     pins.error    = 1'b1;
                     refusals++;
                  end else begin
                     chan          = item.channel[ChanSelW-1:0];
                     reads_total   = item.read_count;
                     reads_left    = item.read_count;
                     sum           = 0;
                     pins.busy_res = 1'b1;
                     start_frame();
                  end
               end
            end
            SEQ_SETUP: begin
               pins.busy_res = 1'b1;
               start_frame();
            end
            SEQ_CMD_LOW, SEQ_CMD_HIGH: begin
               pins.busy_res = 1'b1;
               pins.cs_n     = 1'b0;
               pins.mosi     = cmd_bits[CmdShiftW-1];
               if (phase == SEQ_CMD_LOW) begin
                  if (phase_done()) phase = SEQ_CMD_HIGH;
               end else begin
                  pins.sclk = 1'b1;
                  if (phase_done()) begin
                     cmd_bits = cmd_bits << 1;
                     bit_count++;
                     if (bit_count >= CommandBits) begin
                        bit_count = '0;
                        phase     = SEQ_RX_LOW;
                     end else begin
                        phase = SEQ_CMD_LOW;
                     end
                  end
               end
            end
            SEQ_RX_LOW: begin
               pins.busy_res = 1'b1;
               pins.cs_n     = 1'b0;
               // sample just after the falling edge of the previous receive pulse
               if (tick_count == 0 && bit_count > 0) shift_in(item.miso);
               if (phase_done()) phase = SEQ_RX_HIGH;
            end
            SEQ_RX_HIGH: begin
               pins.busy_res = 1'b1;
               pins.cs_n     = 1'b0;
               pins.sclk     = 1'b1;
               if (phase_done()) begin
                  bit_count++;
                  if (bit_count >= RxBits) begin
                     bit_count = '0;
                     phase     = SEQ_TAIL;
                  end else begin
                     phase = SEQ_RX_LOW;
                  end
               end
            end
            SEQ_TAIL: begin
               pins.busy_res = 1'b1;
               pins.cs_n     = 1'b0;
               if (tick_count == 0) shift_in(item.miso);
               if (phase_done()) begin
                  // last received bit is dropped
                  sum += 32'(rx_bits >> 1);
                  if (reads_left > 0) reads_left--;
                  if (reads_left == 0) begin
                     q        = sum / 32'(reads_total);
                     quotient = (q > AvgMax) ? AvgMax : q[AvgW-1:0];
                     phase    = SEQ_FINISH;
                  end else begin
                     phase = SEQ_SETUP;
                  end
               end
            end
            SEQ_FINISH: begin
               pins.done_res = 1'b1;
               pins.average  = quotient;
               phase         = SEQ_IDLE;
               conversions++;
            end
            default: phase = SEQ_IDLE;
         endcase
         return pins;
      endfunction

      function void note_tick(req_type item);
         ticks++;
         expected_pins.push_back(predict_tick(item));
      endfunction

      function string pins_text(rsp_type p);
         return $sformatf("sclk %b mosi %b cs_n %b busy %b done %b err %b avg %0d",
                          p.sclk, p.mosi, p.cs_n, p.busy_res, p.done_res, p.error,
                          p.average);
      endfunction

      function void check_pins(rsp_type got);
         rsp_type want;
         if (expected_pins.size() == 0) begin
            mismatches++;
            if (mismatches <= MaxReport)
               $display("unexpected output item: %s", pins_text(got));
            return;
         end
         want = expected_pins.pop_front();
         if (got.sclk !== want.sclk || got.mosi !== want.mosi || got.cs_n !== want.cs_n ||
             got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
             got.error !== want.error || got.average !== want.average) begin
            mismatches++;
            if (mismatches <= MaxReport)
               $display("mismatch at output item %0d\n  expected %s\n  actual   %s",
                        ticks - expected_pins.size() - 1, pins_text(want), pins_text(got));
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_data;
   logic                   csr_we;
   logic [HalfPeriodW-1:0] csr_wdata;

   pin_trace_checker readers = new();

   int burst_left = 0;

   spi_adc_channel_reader_averaging #(
      .RECEIVE_BITS(RxBits)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Receiver: pick always-ready, random stalls or a repeating 8-bit stall mask.
   int         stall_cycle = 0;
   int         stall_mode  = 0;
   logic [7:0] stall_mask  = 8'hFF;
   always @(posedge clock) begin
      if (stall_cycle % 256 == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_mask = 8'($urandom) | 8'h01;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= stall_mask[stall_cycle % 8];
      endcase
      stall_cycle++;
   end

   // Every accepted output item is checked against the oldest predicted tick.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) readers.check_pins(rsp_data);
   end

   // Sender: bursts of random length, random gaps (often none) between them.
   // The item is handed to the predictor at the edge that accepts it.
   task automatic send_tick(req_type item);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      readers.note_tick(item);
   endtask

   // Random tick; fields that the sequencer ignores while busy get their full range.
   function automatic req_type random_tick(bit allow_start);
      req_type item;
      int      pick;
      item.start_req = allow_start && ($urandom_range(0, 3) == 0);
      item.channel   = ($urandom_range(0, 99) < 85) ? ChannelW'($urandom_range(0, 7))
                                                    : ChannelW'($urandom_range(8, 15));
      pick = $urandom_range(0, 99);
      if (!readers.is_idle())
         item.read_count = ReadCountW'($urandom_range(0, 255));
      else if (pick < 5)
         item.read_count = '0;
      else if (pick < 90)
         item.read_count = ReadCountW'($urandom_range(1, 3));
      else
         item.read_count = ReadCountW'($urandom_range(4, 12));
      item.miso = 1'($urandom_range(0, 1));
      return item;
   endfunction

   // One averaged conversion from an idle sequencer; poke_busy repeats start while busy.
   task automatic run_conversion(logic [ChannelW-1:0] ch, logic [ReadCountW-1:0] count,
                                 int miso_style, bit poke_busy);
      req_type item;
      item = '{start_req: 1'b1, channel: ch, read_count: count, miso: 1'b0};
      send_tick(item);
      while (!readers.is_idle()) begin
         item.start_req  = poke_busy;
         item.channel    = ChannelW'($urandom_range(0, 15));
         item.read_count = ReadCountW'($urandom_range(0, 255));
         case (miso_style)
            MisoZeros: item.miso = 1'b0;
            MisoOnes:  item.miso = 1'b1;
            default:   item.miso = 1'($urandom_range(0, 1));
         endcase
         send_tick(item);
      end
   endtask

   // Finish any running conversion, let the output side empty, then write the half period.
   task automatic write_half_period(logic [HalfPeriodW-1:0] value);
      while (!readers.is_idle()) send_tick(random_tick(1'b0));
      req_valid <= 1'b0;
      burst_left = 0;
      while (readers.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      readers.half_period = value;
   endtask

   initial begin
      repeat (CycleLimit) @(posedge clock);
      $display("simulation failed");
      $finish;
   end

   initial begin
      logic [HalfPeriodW-1:0] random_halves[5];
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_wdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed, at the reset half period of 200 ticks: refusals and idle ticks ---
      send_tick('{start_req: 1'b0, channel: 4'd15, read_count: 8'd255, miso: 1'b1});
      send_tick('{start_req: 1'b1, channel: 4'd15, read_count: 8'd1,   miso: 1'b0}); // bad ch
      send_tick('{start_req: 1'b1, channel: 4'd8,  read_count: 8'd200, miso: 1'b1}); // bad ch
      send_tick('{start_req: 1'b1, channel: 4'd3,  read_count: 8'd0,   miso: 1'b0}); // no reads
      send_tick('{start_req: 1'b1, channel: 4'd15, read_count: 8'd0,   miso: 1'b1}); // both bad
      send_tick('{start_req: 1'b0, channel: 4'd0,  read_count: 8'd0,   miso: 1'b0});

      // zero half period behaves as one tick; all-ones data -> max average
      write_half_period(16'd0);
      run_conversion(4'd7, 8'd1, MisoRandom, 1'b1);   // starts while busy and on done: ignored
      run_conversion(4'd0, 8'd4, MisoOnes, 1'b1);

      write_half_period(16'd1);
      run_conversion(4'd5, 8'd2, MisoZeros, 1'b0);
      run_conversion(4'd2, 8'd3, MisoRandom, 1'b1);

      // longest half period: refusals and idle ticks only, a frame would take millions of ticks
      write_half_period(16'hFFFF);
      send_tick('{start_req: 1'b1, channel: 4'd9, read_count: 8'd200, miso: 1'b0});
      send_tick('{start_req: 1'b1, channel: 4'd2, read_count: 8'd0,   miso: 1'b1});
      send_tick('{start_req: 1'b0, channel: 4'd7, read_count: 8'd128, miso: 1'b1});

      // --- random: short half periods so many conversions fit ---
      random_halves = '{16'd1, 16'd2, 16'd0, 16'd3, 16'd1};
      random_halves[4] = HalfPeriodW'($urandom_range(1, 4));
      foreach (random_halves[p]) begin
         write_half_period(random_halves[p]);
         repeat (200) send_tick(random_tick(1'b1));
      end

      req_valid <= 1'b0;
      while (readers.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);

      $display("ticks %0d: %0d averaged conversions, %0d refused requests",
               readers.ticks, readers.conversions, readers.refusals);
      $display("conversions at half periods 0..4, refusals at 200 and 65535; %0d bad items",
               readers.mismatches);
      if (readers.mismatches == 0 && readers.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/spiadc_pkg.sv
design/spiadc_div.sv
design/spiadc_dpath.sv
design/spiadc_ctrl.sv
design/spi_adc_channel_reader_averaging.sv
design/spiadc_checker.sv
sim/spi_adc_channel_reader_averaging_test.sv
